/* hdl/cbc_pkg.sv */
// ---------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the direct-mapped block cache.
// ---------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

   localparam int ENTRIES_DEFAULT   = 16;
   localparam int DATA_BITS_DEFAULT = 64;
   localparam int MIN_ENTRIES       = 5;
   localparam int MAX_RESULTS       = 16;
   localparam logic [4:0] ENTRIES_RESET = 5'd16;
   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   localparam logic CSR_ENTRIES_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      OP_STORE  = 3'd0,
      OP_LOOKUP = 3'd1,
      OP_INVAL  = 3'd2,
      OP_FREE   = 3'd3,
      OP_FLUSH  = 3'd4,
      OP_DIRTY  = 3'd5,
      OP_VICTIM = 3'd6
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_ACK     = 3'd0,
      KIND_LOOKUP  = 3'd1,
      KIND_WB      = 3'd2,
      KIND_NOTHING = 3'd3,
      KIND_DIRTY   = 3'd4,
      KIND_VICTIM  = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] block_number;
      logic [63:0] block_data;
      logic        dirty_flag;
      logic [31:0] timestamp;
      logic [3:0]  slot_select;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic        hit;
      logic [63:0] read_data;
      logic [31:0] writeback_block;
      logic [3:0]  victim_slot;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV,
      ST_RD,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_FINAL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic simple;
      logic div_step;
      logic rd_slot;
      logic exec;
      logic scan_rd;
      logic scan_ev;
      logic final_rsp;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       div_done;
      logic       scan_last;
      logic       rsp_busy;
   } status_type;

endpackage

`default_nettype wire

/* hdl/cbc_ram.sv */
// ---------------------------------------------------------------------------
// cbc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hdl/cbc_controller.sv */
// ---------------------------------------------------------------------------
// cbc_controller
// Sequencer: divide, read, execute, scan and response handoff.
// ---------------------------------------------------------------------------
`default_nettype none

module cbc_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire cbc_pkg::status_type status,
   output cbc_pkg::cmd_type         cmd
);
   import cbc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.opcode == OP_STORE || status.opcode == OP_LOOKUP) begin
               state_in = ST_DIV;
            end else if (status.opcode == OP_FLUSH || status.opcode == OP_DIRTY ||
                         status.opcode == OP_VICTIM) begin
               state_in = ST_SCAN_RD;
            end else begin
               cmd.simple = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd_slot = 1'b1;
            state_in    = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESP;
         end
         ST_SCAN_RD: begin
            if (!status.rsp_busy) begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            state_in    = status.scan_last ? ST_FINAL : ST_SCAN_RD;
         end
         ST_FINAL: begin
            if (!status.rsp_busy) begin
               cmd.final_rsp = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/cbc_datapath.sv */
// ---------------------------------------------------------------------------
// cbc_datapath
// Slot stores, remainder unit, scan accumulators, response register, CSR.
// ---------------------------------------------------------------------------
`default_nettype none

module cbc_datapath #(
   parameter int ENTRIES   = cbc_pkg::ENTRIES_DEFAULT,
   parameter int DATA_BITS = cbc_pkg::DATA_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cbc_pkg::req_type req_payload,
   input  wire cbc_pkg::cmd_type cmd,
   output cbc_pkg::status_type   status,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cbc_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic             csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata
);
   import cbc_pkg::*;

   localparam int SLOT_BITS = $clog2(ENTRIES);

   logic [4:0]           cfg_ff, cfg_in;
   req_type              req_ff, req_in;
   logic [5:0]           rem_ff, rem_in;
   logic [4:0]           div_cnt_ff, div_cnt_in;
   logic [SLOT_BITS-1:0] scan_idx_ff, scan_idx_in;
   logic [SLOT_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [ENTRIES-1:0]   dirty_ff, dirty_in;
   logic [ENTRIES-1:0]   written_ff, written_in;
   logic                 any_ff, any_in;
   logic [31:0]          best_ff, best_in;
   logic [SLOT_BITS-1:0] pick_ff, pick_in;
   logic [4:0]           wb_cnt_ff, wb_cnt_in;
   logic                 pend_ff, pend_in;
   logic [DATA_BITS-1:0] pend_data_ff, pend_data_in;
   logic [31:0]          pend_tag_ff, pend_tag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [5:0]           n_num;
   logic [5:0]           trial;
   logic [SLOT_BITS-1:0] slot;
   logic [SLOT_BITS-1:0] raddr;
   logic                 tag_we, data_we, time_we;
   logic [31:0]          time_wd;
   logic [31:0]          tag_q, time_q, time_rd;
   logic [DATA_BITS-1:0] data_q, cur_data, new_data;
   logic                 found;

   cbc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_tag_ram (
      .clock(clock), .we(tag_we), .waddr(slot), .wdata(req_ff.block_number),
      .raddr(raddr), .rdata(tag_q)
   );

   cbc_ram #(.WIDTH(DATA_BITS), .DEPTH(ENTRIES)) u_data_ram (
      .clock(clock), .we(data_we), .waddr(slot), .wdata(new_data),
      .raddr(raddr), .rdata(data_q)
   );

   cbc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_time_ram (
      .clock(clock), .we(time_we), .waddr(slot), .wdata(time_wd),
      .raddr(raddr), .rdata(time_q)
   );

   always_comb begin
      if (32'(cfg_ff) < MIN_ENTRIES) begin
         n_num = 6'(MIN_ENTRIES);
      end else if (32'(cfg_ff) > ENTRIES) begin
         n_num = 6'(ENTRIES);
      end else begin
         n_num = {1'b0, cfg_ff};
      end
   end

   assign trial    = {rem_ff[4:0], req_ff.block_number[5'd31 - div_cnt_ff]};
   assign slot     = SLOT_BITS'(rem_ff);
   assign raddr    = cmd.rd_slot ? slot : scan_idx_ff;
   assign new_data = req_ff.block_data[DATA_BITS-1:0];
   assign cur_data = written_ff[rd_idx_ff] ? data_q : '0;
   assign time_rd  = written_ff[rd_idx_ff] ? time_q : '0;
   assign found    = valid_ff[rd_idx_ff] & dirty_ff[rd_idx_ff];

   assign status.opcode    = req_ff.opcode;
   assign status.div_done  = (div_cnt_ff == 5'd31);
   assign status.rsp_busy  = rsp_valid_ff;
   assign status.scan_last = (32'(scan_idx_ff) == 32'(n_num) - 1) ||
                             (req_ff.opcode == OP_FLUSH && found &&
                              wb_cnt_ff == 5'(MAX_RESULTS - 1));

   always_comb begin
      cfg_in       = cfg_ff;
      req_in       = req_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      scan_idx_in  = scan_idx_ff;
      rd_idx_in    = rd_idx_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      written_in   = written_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      wb_cnt_in    = wb_cnt_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      pend_tag_in  = pend_tag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      tag_we       = 1'b0;
      data_we      = 1'b0;
      time_we      = 1'b0;
      time_wd      = '0;

      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ENTRIES_IN_USE) begin
         cfg_in = csr_pwdata[4:0];
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.accept) begin
         req_in      = req_payload;
         rem_in      = '0;
         div_cnt_in  = '0;
         scan_idx_in = '0;
         any_in      = 1'b0;
         best_in     = TIME_MAX;
         pick_in     = '0;
         wb_cnt_in   = '0;
         pend_in     = 1'b0;
      end

      if (cmd.div_step) begin
         rem_in     = (trial >= n_num) ? trial - n_num : trial;
         div_cnt_in = div_cnt_ff + 5'd1;
      end

      if (cmd.rd_slot) begin
         rd_idx_in = slot;
      end
      if (cmd.scan_rd) begin
         rd_idx_in = scan_idx_ff;
      end

      if (cmd.simple) begin
         if (req_ff.opcode == OP_INVAL) begin
            valid_in = '0;
         end else if (req_ff.opcode == OP_FREE && 32'(req_ff.slot_select) < ENTRIES) begin
            valid_in[SLOT_BITS'(req_ff.slot_select)] = 1'b0;
         end
         rsp_in             = '0;
         rsp_in.result_kind = KIND_ACK;
         rsp_in.last        = 1'b1;
         rsp_valid_in       = 1'b1;
      end

      if (cmd.exec) begin
         rsp_in       = '0;
         rsp_in.last  = 1'b1;
         rsp_valid_in = 1'b1;
         if (req_ff.opcode == OP_STORE) begin
            rsp_in.result_kind = KIND_ACK;
            if (cur_data != new_data) begin
               tag_we           = 1'b1;
               data_we          = 1'b1;
               time_we          = 1'b1;
               valid_in[slot]   = 1'b1;
               written_in[slot] = 1'b1;
               dirty_in[slot]   = req_ff.dirty_flag;
            end
         end else begin
            rsp_in.result_kind = KIND_LOOKUP;
            if (valid_ff[slot] && tag_q == req_ff.block_number) begin
               time_we          = 1'b1;
               time_wd          = req_ff.timestamp;
               rsp_in.hit       = 1'b1;
               rsp_in.read_data = 64'(cur_data);
            end
         end
      end

      if (cmd.scan_ev) begin
         scan_idx_in = scan_idx_ff + SLOT_BITS'(1);
         case (req_ff.opcode)
            OP_FLUSH: begin
               if (found) begin
                  dirty_in[rd_idx_ff] = 1'b0;
                  wb_cnt_in           = wb_cnt_ff + 5'd1;
                  pend_in             = 1'b1;
                  pend_data_in        = cur_data;
                  pend_tag_in         = tag_q;
                  if (pend_ff) begin
                     rsp_in                 = '0;
                     rsp_in.result_kind     = KIND_WB;
                     rsp_in.read_data       = 64'(pend_data_ff);
                     rsp_in.writeback_block = pend_tag_ff;
                     rsp_valid_in           = 1'b1;
                  end
               end
            end
            OP_DIRTY: begin
               if (found) begin
                  any_in = 1'b1;
               end
            end
            OP_VICTIM: begin
               if (!dirty_ff[rd_idx_ff] && time_rd < best_ff) begin
                  best_in = time_rd;
                  pick_in = rd_idx_ff;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.final_rsp) begin
         rsp_in       = '0;
         rsp_in.last  = 1'b1;
         rsp_valid_in = 1'b1;
         case (req_ff.opcode)
            OP_FLUSH: begin
               if (pend_ff) begin
                  rsp_in.result_kind     = KIND_WB;
                  rsp_in.read_data       = 64'(pend_data_ff);
                  rsp_in.writeback_block = pend_tag_ff;
               end else begin
                  rsp_in.result_kind = KIND_NOTHING;
               end
            end
            OP_DIRTY: begin
               rsp_in.result_kind = KIND_DIRTY;
               rsp_in.hit         = any_ff;
            end
            default: begin
               rsp_in.result_kind = KIND_VICTIM;
               rsp_in.victim_slot = 4'(pick_ff);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= ENTRIES_RESET;
         div_cnt_ff   <= '0;
         scan_idx_ff  <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         written_ff   <= '0;
         any_ff       <= 1'b0;
         wb_cnt_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         div_cnt_ff   <= div_cnt_in;
         scan_idx_ff  <= scan_idx_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         written_ff   <= written_in;
         any_ff       <= any_in;
         wb_cnt_ff    <= wb_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rem_ff       <= rem_in;
      rd_idx_ff    <= rd_idx_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      pend_data_ff <= pend_data_in;
      pend_tag_ff  <= pend_tag_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_prdata  = (csr_paddr == CSR_ENTRIES_IN_USE) ? {27'b0, cfg_ff} : '0;

endmodule

`default_nettype wire

/* hdl/direct_mapped_block_cache.sv */
// ---------------------------------------------------------------------------
// direct_mapped_block_cache
// Direct-mapped write-back block cache, one data word per block.
//
// channel   handshake               payload
// req       req_valid / req_ready   req_payload (req_type)
// rsp       rsp_valid / rsp_ready   rsp_payload (rsp_type)
// csr       APB psel/penable        entries_in_use at address 0
//
// Store and lookup: the slot is set by the 32-step serial remainder, then
// read through the registered RAM read port and the command executed.
// Flush, dirty and victim queries scan the slots one at a time, reading
// each slot through the registered RAM read port and then evaluating it.
// Other commands are answered directly from dispatch.
// One command in flight; a pending response stalls the flush scan.
// Synchronous reset; no clearing pass (written bits mask the RAMs).
// ---------------------------------------------------------------------------
`default_nettype none

module direct_mapped_block_cache #(
   parameter int ENTRIES   = cbc_pkg::ENTRIES_DEFAULT,
   parameter int DATA_BITS = cbc_pkg::DATA_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cbc_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cbc_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic             csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready
);
   import cbc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   cbc_controller u_controller (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   cbc_datapath #(.ENTRIES(ENTRIES), .DATA_BITS(DATA_BITS)) u_datapath (
      .clock(clock), .reset(reset), .req_payload(req_payload), .cmd(cmd),
      .status(status), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata)
   );

endmodule

`default_nettype wire

/* hdl/cbc_checker.sv */
// ---------------------------------------------------------------------------
// cbc_checker
// Port-level checks of the block cache, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cbc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire cbc_pkg::rsp_type rsp_payload
);
   import cbc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp transfer dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while a command is in flight");

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready for a command with a response outstanding");

   a_only_wb_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> rsp_payload.result_kind == KIND_WB)
      else $error("non-final transfer that is not a write-back");

endmodule

bind direct_mapped_block_cache cbc_checker u_checker (.*);

`default_nettype wire

/* tb/tb_direct_mapped_block_cache.sv */
// ---------------------------------------------------------------------------
// tb_direct_mapped_block_cache
// Self-checking testbench of the direct-mapped block cache.
// Drives commands over the req channel, predicts every rsp transfer in a
// scoreboard that keeps its own copy of the cache state, and walks several
// entries_in_use settings with random idling and backpressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_direct_mapped_block_cache;
   import cbc_pkg::*;

   localparam int NSLOT = ENTRIES_DEFAULT;
   localparam int WATCHDOG_LIMIT = 20000;

   class cache_scoreboard;
      logic [31:0] tags [NSLOT];
      logic [63:0] words [NSLOT];
      bit          vld [NSLOT];
      bit          drt [NSLOT];
      logic [31:0] atime [NSLOT];
      logic [4:0]  entries_cfg;
      rsp_type     pending [$];
      int          mismatches;

      function void clear();
         for (int i = 0; i < NSLOT; i++) begin
            tags[i] = '0; words[i] = '0; vld[i] = 0; drt[i] = 0; atime[i] = '0;
         end
         entries_cfg = ENTRIES_RESET;
         pending.delete();
         mismatches = 0;
      endfunction

      function rsp_type mk(kind_type k, logic h, logic [63:0] d, logic [31:0] b,
                           logic [3:0] s, logic l);
         rsp_type r;
         r.result_kind = k; r.hit = h; r.read_data = d;
         r.writeback_block = b; r.victim_slot = s; r.last = l;
         return r;
      endfunction

      function void note_request(req_type q);
         int n, slot, cnt;
         logic [31:0] best;
         bit any;
         n = entries_cfg < MIN_ENTRIES ? MIN_ENTRIES :
             (entries_cfg > NSLOT ? NSLOT : int'(entries_cfg));
         slot = q.block_number % n;
         case (q.opcode)
            OP_STORE: begin
               if (words[slot] != q.block_data) begin
                  words[slot] = q.block_data; tags[slot] = q.block_number;
                  vld[slot] = 1; atime[slot] = '0; drt[slot] = q.dirty_flag;
               end
               pending.push_back(mk(KIND_ACK, 0, 0, 0, 0, 1));
            end
            OP_LOOKUP: begin
               if (vld[slot] && tags[slot] == q.block_number) begin
                  atime[slot] = q.timestamp;
                  pending.push_back(mk(KIND_LOOKUP, 1, words[slot], 0, 0, 1));
               end else
                  pending.push_back(mk(KIND_LOOKUP, 0, 0, 0, 0, 1));
            end
            OP_INVAL: begin
               for (int i = 0; i < NSLOT; i++) vld[i] = 0;
               pending.push_back(mk(KIND_ACK, 0, 0, 0, 0, 1));
            end
            OP_FREE: begin
               vld[q.slot_select] = 0;
               pending.push_back(mk(KIND_ACK, 0, 0, 0, 0, 1));
            end
            OP_FLUSH: begin
               cnt = 0;
               for (int i = 0; i < n && cnt < MAX_RESULTS; i++)
                  if (vld[i] && drt[i]) begin
                     pending.push_back(mk(KIND_WB, 0, words[i], tags[i], 0, 0));
                     drt[i] = 0; cnt++;
                  end
               if (cnt == 0) pending.push_back(mk(KIND_NOTHING, 0, 0, 0, 0, 1));
               else pending[$].last = 1;
            end
            OP_DIRTY: begin
               any = 0;
               for (int i = 0; i < n; i++) if (vld[i] && drt[i]) any = 1;
               pending.push_back(mk(KIND_DIRTY, any, 0, 0, 0, 1));
            end
            OP_VICTIM: begin
               best = TIME_MAX; slot = 0;
               for (int i = 0; i < n; i++)
                  if (!drt[i] && atime[i] < best) begin best = atime[i]; slot = i; end
               pending.push_back(mk(KIND_VICTIM, 0, 0, 0, slot[3:0], 1));
            end
            default: pending.push_back(mk(KIND_ACK, 0, 0, 0, 0, 1));
         endcase
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp transfer %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("rsp mismatch: expected kind %0d hit %0d data %h blk %h slot %0d last %0d",
                  want.result_kind, want.hit, want.read_data, want.writeback_block,
                  want.victim_slot, want.last);
               $display("              actual kind %0d hit %0d data %h blk %h slot %0d last %0d",
                  got.result_kind, got.hit, got.read_data, got.writeback_block,
                  got.victim_slot, got.last);
            end
         end
      endfunction
   endclass

   logic    clock = 0, reset = 1;
   logic    req_valid = 0, rsp_ready = 0, req_ready, rsp_valid;
   req_type req_payload = '0;
   rsp_type rsp_payload;
   logic    csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_paddr = 0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic    csr_pready;

   cache_scoreboard sb;
   int  send_idle_pct = 0, recv_idle_pct = 0;
   bit  hold_off = 0;
   int  quiet_cycles = 0;
   logic [31:0] blk_pool [8];

   always begin #10 clock = 1; #10 clock = 0; end

   direct_mapped_block_cache u_dut (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
      rsp_ready <= !reset && !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_request(req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_payload <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(q);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_entries(logic [4:0] v);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_ENTRIES_IN_USE; csr_pwdata <= {27'd0, v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sb.entries_cfg = v;
      @(posedge clock);
   endtask

   function automatic req_type mkreq(opcode_type op, logic [31:0] b, logic [63:0] d,
                                     logic df, logic [31:0] ts, logic [3:0] s);
      req_type q;
      q.opcode = op; q.block_number = b; q.block_data = d;
      q.dirty_flag = df; q.timestamp = ts; q.slot_select = s;
      return q;
   endfunction

   function automatic req_type random_request();
      req_type q;
      int p;
      q.block_number = $urandom;
      q.block_data   = {$urandom, $urandom};
      q.dirty_flag   = 1'($urandom);
      q.timestamp    = $urandom;
      q.slot_select  = 4'($urandom);
      p = $urandom_range(99);
      if (p < 30) q.opcode = OP_STORE;
      else if (p < 58) q.opcode = OP_LOOKUP;
      else if (p < 61) q.opcode = OP_INVAL;
      else if (p < 68) q.opcode = OP_FREE;
      else if (p < 80) q.opcode = OP_FLUSH;
      else if (p < 88) q.opcode = OP_DIRTY;
      else if (p < 97) q.opcode = OP_VICTIM;
      else q.opcode = 3'd7;
      if ($urandom_range(9) < 8) q.block_number = blk_pool[$urandom_range(7)];
      if ($urandom_range(9) == 0) q.block_data = '0;
      return q;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_request(random_request());
   endtask

   initial begin
      sb = new();
      sb.clear();
      for (int i = 0; i < 8; i++) blk_pool[i] = $urandom_range(40);
      blk_pool[7] = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send_request(mkreq(OP_STORE, 32'd3, 64'd0, 1, 0, 0));
      send_request(mkreq(OP_LOOKUP, 32'd3, 0, 0, 32'd5, 0));
      send_request(mkreq(OP_STORE, 32'hFFFF_FFFF, '1, 1, 0, 0));
      send_request(mkreq(OP_STORE, 32'hFFFF_FFFF, '1, 0, 0, 0));
      send_request(mkreq(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0));
      send_request(mkreq(OP_STORE, 32'd16, 64'h1234, 1, 0, 0));
      send_request(mkreq(OP_LOOKUP, 32'd0, 0, 0, 32'd9, 0));
      send_request(mkreq(OP_DIRTY, 0, 0, 0, 0, 0));
      send_request(mkreq(OP_VICTIM, 0, 0, 0, 0, 0));
      send_request(mkreq(OP_FLUSH, 0, 0, 0, 0, 0));
      send_request(mkreq(OP_FLUSH, 0, 0, 0, 0, 0));
      send_request(mkreq(OP_FREE, 0, 0, 0, 0, 4'd15));
      send_request(mkreq(OP_FREE, 0, 0, 0, 0, 4'd0));
      send_request(mkreq(OP_LOOKUP, 32'd16, 0, 0, 0, 0));
      send_request(mkreq(OP_INVAL, 0, 0, 0, 0, 0));
      send_request(mkreq(opcode_type'(3'd7), '1, '1, 1, '1, '1));
      for (int i = 0; i < NSLOT; i++)
         send_request(mkreq(OP_STORE, 32'(i), {$urandom, $urandom} | 64'd1, 1, 0, 0));
      send_request(mkreq(OP_FLUSH, 0, 0, 0, 0, 0));
      drain();

      write_entries(5'd5);
      send_idle_pct = 36; recv_idle_pct = 71;
      random_phase(70);
      drain();

      write_entries(5'd0);
      send_idle_pct = 71; recv_idle_pct = 36;
      random_phase(60);
      drain();

      write_entries(5'd31);
      send_idle_pct = 0; recv_idle_pct = 0;
      fork
         begin hold_off = 1; repeat (600) @(posedge clock); hold_off = 0; end
         random_phase(40);
      join
      drain();

      write_entries(5'd11);
      random_phase(60);
      drain();
      write_entries(5'd16);
      random_phase(60);
      drain();

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
